// ----- rtl/fts_pkg.sv -----
// Package for the float text syntax checker.
// Holds the recogniser phase type and the character constants; no dependencies.
`default_nettype none

package fts_pkg;

  localparam int unsigned CharW = 8;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_SIGNED   = 4'd1,
    PH_N        = 4'd2,
    PH_NA       = 4'd3,
    PH_I        = 4'd4,
    PH_IN       = 4'd5,
    PH_WORD     = 4'd6,
    PH_INT      = 4'd7,
    PH_DOT      = 4'd8,
    PH_FRAC     = 4'd9,
    PH_EXP      = 4'd10,
    PH_EXP_SIGN = 4'd11,
    PH_EXP_DIG  = 4'd12,
    PH_DEAD     = 4'd13
  } phase_t;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPoint = 8'h2E;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpE   = 8'h45;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowE  = 8'h65;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChLowI  = 8'h69;
  localparam logic [CharW-1:0] ChLowN  = 8'h6E;

  typedef struct packed {
    phase_t phase_next;
    logic   accepting;
  } step_t;

endpackage

`default_nettype wire

// ----- rtl/fts_if.sv -----
// Handshake channels of the float text syntax checker: text bytes in, verdicts out.
// Depends on fts_pkg for the character width.
`default_nettype none

interface fts_char_if import fts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface fts_verdict_if;
  logic valid;
  logic ready;
  logic text_valid;

  modport source (output valid, output text_valid, input ready);
  modport sink   (input valid, input text_valid, output ready);
endinterface

`default_nettype wire

// ----- rtl/fts_phase_next.sv -----
// Next-phase decoder of the float text recogniser.
// Depends on fts_pkg for the phase type and character constants.
`default_nettype none

module fts_phase_next import fts_pkg::*; (
  input  phase_t           phase,
  input  logic [CharW-1:0] char_code,
  output step_t            step
);

  logic   is_digit;
  logic   is_sign;
  logic   is_exp;
  phase_t body;
  phase_t nx;

  assign is_digit = (char_code >= ChZero) && (char_code <= ChNine);
  assign is_sign  = (char_code == ChPlus) || (char_code == ChMinus);
  assign is_exp   = (char_code == ChLowE) || (char_code == ChUpE);

  // first byte of the body, after an optional sign
  always_comb begin
    if (char_code == ChLowN)       body = PH_N;
    else if (char_code == ChLowI)  body = PH_I;
    else if (is_digit)             body = PH_INT;
    else if (char_code == ChPoint) body = PH_DOT;
    else                           body = PH_DEAD;
  end

  always_comb begin
    unique case (phase)
      PH_START:  nx = is_sign ? PH_SIGNED : body;
      PH_SIGNED: nx = body;
      PH_N:      nx = (char_code == ChLowA) ? PH_NA : PH_DEAD;
      PH_NA:     nx = (char_code == ChLowN) ? PH_WORD : PH_DEAD;
      PH_I:      nx = (char_code == ChLowN) ? PH_IN : PH_DEAD;
      PH_IN:     nx = (char_code == ChLowF) ? PH_WORD : PH_DEAD;
      PH_INT: begin
        if (is_digit)                nx = PH_INT;
        else if (char_code == ChPoint) nx = PH_FRAC;
        else if (is_exp)             nx = PH_EXP;
        else                         nx = PH_DEAD;
      end
      PH_DOT:    nx = is_digit ? PH_FRAC : PH_DEAD;
      PH_FRAC: begin
        if (is_digit)    nx = PH_FRAC;
        else if (is_exp) nx = PH_EXP;
        else             nx = PH_DEAD;
      end
      PH_EXP: begin
        if (is_sign)       nx = PH_EXP_SIGN;
        else if (is_digit) nx = PH_EXP_DIG;
        else               nx = PH_DEAD;
      end
      PH_EXP_SIGN, PH_EXP_DIG: nx = is_digit ? PH_EXP_DIG : PH_DEAD;
      default:   nx = PH_DEAD; // dead phase and unused codes
    endcase
  end

  assign step.phase_next = nx;
  assign step.accepting  = (nx == PH_WORD) || (nx == PH_INT) || (nx == PH_FRAC) ||
                           (nx == PH_EXP_DIG);

endmodule

`default_nettype wire

// ----- rtl/float_text_syntax_checker_core.sv -----
// Top level of the float text syntax checker: input register, phase register, verdict register.
// Depends on fts_pkg, fts_if and fts_phase_next.
`default_nettype none

//  channel   | dir | payload                 | request means
//  ----------+-----+-------------------------+--------------------------------
//  char_in   | in  | char_code, final_char   | one byte of the number text
//  verdict   | out | text_valid              | verdict on a text, at its last byte
//
//  Flow: one byte per clock while the input is not stalled (see Stalls); a verdict
//  passes through the input register and then the verdict register before it is
//  presented. The phase update is one combinational decoder between the input
//  register and the phase register.
//  Reset: rst clears the phase to start of text and empties both registers.
//  Stalls: while a verdict waits, bytes that are not last keep flowing; only a
//  second last byte waits in the input register until the verdict is taken.

module float_text_syntax_checker_core import fts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  fts_char_if.sink      char_in,
  fts_verdict_if.source verdict
);

  // input register
  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_final;

  // recogniser state and verdict register
  phase_t phase;
  logic   out_valid;
  logic   out_text_valid;

  step_t  step;
  logic   out_free;
  logic   s1_advance;
  logic   s1_take;

  fts_phase_next u_phase_next (
    .phase     (phase),
    .char_code (s1_char),
    .step      (step)
  );

  // the verdict slot is free when empty or being drained this cycle
  assign out_free   = !out_valid || verdict.ready;
  // a byte that is not last needs no slot; a last byte needs the verdict slot
  assign s1_advance = s1_valid && (!s1_final || out_free);
  assign s1_take    = char_in.valid && char_in.ready;

  assign char_in.ready = !s1_valid || s1_advance;

  // hold or load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_char  <= char_in.char_code;
      s1_final <= char_in.final_char;
    end
  end

  // advance the phase; go back to start of text after each verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else if (s1_advance) begin
      phase <= s1_final ? PH_START : step.phase_next;
    end
  end

  // verdict register: load on a last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_final) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_final) begin
      out_text_valid <= step.accepting;
    end
  end

  assign verdict.valid      = out_valid;
  assign verdict.text_valid = out_text_valid;

  // after a verdict the recogniser must be back at the start of text
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_final) |=> (phase == PH_START))
    else $error("phase not at start after a verdict");

  // a new verdict only ever comes from a last byte in the input register
  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_final))
    else $error("verdict without a last byte");

  // back-pressure only when a last byte waits on a full verdict slot
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !char_in.ready |-> (s1_valid && s1_final && out_valid && !verdict.ready))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for float_text_syntax_checker_core: streams number texts, predicts
// each verdict and compares it with the one the block returns.
// Depends on fts_pkg, fts_if and the core RTL.
`timescale 1ns / 1ps

module tb;
  import fts_pkg::*;

  localparam int unsigned RandomBytes = 1700;
  localparam int unsigned TailBytes   = 200;   // no idling over the last stretch
  localparam int unsigned TailVerdicts = 30;
  localparam int unsigned DrainCycles = 8;     // wait after the last verdict is returned
  localparam int unsigned StallLimit  = 2000;  // cycles with no handshake on either side

  typedef struct {
    logic [CharW-1:0] code;
    logic             last;
  } text_byte_t;

  logic clk;
  logic rst;

  fts_char_if    char_bus ();
  fts_verdict_if verdict_bus ();

  float_text_syntax_checker_core DUT (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_bus),
    .verdict (verdict_bus)
  );

  // Bytes waiting to be offered, and verdicts predicted but not yet returned.
  text_byte_t       byte_queue[$];
  logic             verdict_queue[$];
  logic [CharW-1:0] draft[$];

  phase_t      text_phase;
  int unsigned error_count;
  int unsigned total_bytes;
  int unsigned total_verdicts;
  int unsigned bytes_issued;
  int unsigned verdicts_seen;
  int unsigned send_gap;
  int unsigned sink_gap;
  int unsigned stall_cycles;
  text_byte_t  next_byte;
  phase_t      phase_after;
  logic        verdict_want;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("[%0t] mismatch: %s (got %0b, expected %0b)", $realtime, what, got, want);
    error_count++;
  endtask

  // Recogniser phase after one byte; unused codes and the dead phase stay dead.
  function automatic phase_t step_text_phase(input phase_t ph, input logic [CharW-1:0] c);
    logic digit;
    logic sign;
    logic expo;
    digit = (c >= ChZero) && (c <= ChNine);
    sign  = (c == ChPlus) || (c == ChMinus);
    expo  = (c == ChLowE) || (c == ChUpE);
    step_text_phase = PH_DEAD;
    case (ph)
      PH_START, PH_SIGNED: begin
        if (ph == PH_START && sign) step_text_phase = PH_SIGNED;
        else if (c == ChLowN) step_text_phase = PH_N;
        else if (c == ChLowI) step_text_phase = PH_I;
        else if (digit) step_text_phase = PH_INT;
        else if (c == ChPoint) step_text_phase = PH_DOT;
      end
      PH_N: if (c == ChLowA) step_text_phase = PH_NA;
      PH_NA: if (c == ChLowN) step_text_phase = PH_WORD;
      PH_I: if (c == ChLowN) step_text_phase = PH_IN;
      PH_IN: if (c == ChLowF) step_text_phase = PH_WORD;
      PH_INT: begin
        if (digit) step_text_phase = PH_INT;
        else if (c == ChPoint) step_text_phase = PH_FRAC;
        else if (expo) step_text_phase = PH_EXP;
      end
      PH_DOT: if (digit) step_text_phase = PH_FRAC;
      PH_FRAC: begin
        if (digit) step_text_phase = PH_FRAC;
        else if (expo) step_text_phase = PH_EXP;
      end
      PH_EXP: begin
        if (sign) step_text_phase = PH_EXP_SIGN;
        else if (digit) step_text_phase = PH_EXP_DIG;
      end
      PH_EXP_SIGN, PH_EXP_DIG: if (digit) step_text_phase = PH_EXP_DIG;
      default: ;
    endcase
  endfunction

  // Move the draft text into the byte queue, flagging its final byte.
  task automatic commit_draft();
    text_byte_t b;
    if (draft.size() == 0) draft.push_back(CharW'($urandom_range(0, 255)));
    foreach (draft[i]) begin
      b.code = draft[i];
      b.last = (i == draft.size() - 1);
      byte_queue.push_back(b);
    end
    total_verdicts++;
    draft.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    commit_draft();
  endtask

  function automatic logic [CharW-1:0] rand_digit();
    rand_digit = ChZero + CharW'($urandom_range(0, 9));
  endfunction

  function automatic logic [CharW-1:0] rand_sign();
    rand_sign = $urandom_range(0, 1) ? ChPlus : ChMinus;
  endfunction

  // Mostly well-formed numbers and words with random content; some noise and damage.
  task automatic make_random_text();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) draft.push_back(CharW'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) != 0) draft.push_back(rand_sign());
      if (kind == 1) begin
        if ($urandom_range(0, 1)) begin
          draft.push_back(ChLowN); draft.push_back(ChLowA); draft.push_back(ChLowN);
        end else begin
          draft.push_back(ChLowI); draft.push_back(ChLowN); draft.push_back(ChLowF);
        end
      end else begin
        n = $urandom_range(0, 4);
        repeat (n) draft.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          draft.push_back(ChPoint);
          n = $urandom_range(0, 4);
          repeat (n) draft.push_back(rand_digit());
        end
        if ($urandom_range(0, 2) == 0) begin
          draft.push_back($urandom_range(0, 1) ? ChLowE : ChUpE);
          if ($urandom_range(0, 1)) draft.push_back(rand_sign());
          n = $urandom_range(0, 3);
          repeat (n) draft.push_back(rand_digit());
        end
      end
    end
    // Damage some texts: overwrite a byte, drop the tail or append a stray byte.
    if (draft.size() != 0 && $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          pos = $urandom_range(0, draft.size() - 1);
          draft[pos] = CharW'($urandom_range(0, 255));
        end
        1: if (draft.size() > 1) void'(draft.pop_back());
        default: draft.push_back(CharW'($urandom_range(0, 255)));
      endcase
    end
    commit_draft();
  endtask

  // Driver: offer queued bytes, predict each verdict as its final byte is taken.
  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid      <= 1'b0;
      char_bus.char_code  <= '0;
      char_bus.final_char <= 1'b0;
      text_phase          <= PH_START;
      send_gap            = 0;
      bytes_issued        = 0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        phase_after = step_text_phase(text_phase, char_bus.char_code);
        if (char_bus.final_char) begin
          verdict_queue.push_back(phase_after == PH_WORD || phase_after == PH_INT ||
                                  phase_after == PH_FRAC || phase_after == PH_EXP_DIG);
          text_phase <= PH_START;
        end else begin
          text_phase <= phase_after;
        end
      end
      // Hold a request until it is taken; only then advance to the next one.
      if (!char_bus.valid || char_bus.ready) begin
        if (send_gap != 0) begin
          char_bus.valid <= 1'b0;
          send_gap--;
        end else if (byte_queue.size() == 0) begin
          char_bus.valid <= 1'b0;
        end else if (bytes_issued + TailBytes < total_bytes && (bytes_issued % 400) < 300 &&
                     $urandom_range(0, 5) == 0) begin
          // Idle: drop valid and set a random idle gap.
          char_bus.valid <= 1'b0;
          send_gap = $urandom_range(0, 2);
        end else begin
          next_byte = byte_queue.pop_front();
          char_bus.valid      <= 1'b1;
          char_bus.char_code  <= next_byte.code;
          char_bus.final_char <= next_byte.last;
          bytes_issued++;
        end
      end
    end
  end

  // Monitor: take verdicts under random back-pressure and check each against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst) begin
      verdict_bus.ready <= 1'b0;
      sink_gap          = 0;
      verdicts_seen     = 0;
    end else begin
      if (verdict_bus.valid && verdict_bus.ready) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch("verdict with no text pending", verdict_bus.text_valid, 1'bx);
        end else begin
          verdict_want = verdict_queue.pop_front();
          if (verdict_bus.text_valid !== verdict_want)
            report_mismatch("text_valid", verdict_bus.text_valid, verdict_want);
        end
        verdicts_seen++;
      end
      if (sink_gap != 0) begin
        verdict_bus.ready <= 1'b0;
        sink_gap--;
      end else if (verdicts_seen + TailVerdicts < total_verdicts && (verdicts_seen % 40) < 30 &&
                   $urandom_range(0, 4) == 0) begin
        verdict_bus.ready <= 1'b0;
        sink_gap = $urandom_range(0, 2);
      end else begin
        verdict_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither side completes a handshake for too long.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else if ((char_bus.valid && char_bus.ready) ||
                 (verdict_bus.valid && verdict_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, stall_cycles);
        $display("float_text_syntax_checker_core test failed");
        $finish;
      end
    end
  end

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    char_bus.valid      = 1'b0;
    char_bus.char_code  = '0;
    char_bus.final_char = 1'b0;
    verdict_bus.ready   = 1'b0;
    error_count         = 0;
    total_verdicts      = 0;

    // Directed texts: sign alone, point alone, trailing and leading point, the special
    // words and a wrong spelling, an exponent without digits, a capital exponent mark,
    // and stray bytes at both ends of the byte range.
    add_text("+");
    add_text(".");
    add_text("5.");
    add_text(".5");
    add_text("nan");
    add_text("inf");
    add_text("nanx");
    add_text("Inf");
    add_text("1e+");
    add_text("-1E9");
    draft.push_back(8'h00);
    commit_draft();
    draft.push_back(8'hFF);
    commit_draft();

    // Random texts, whole texts only so that no text is cut short.
    while (byte_queue.size() < 26 + RandomBytes) make_random_text();
    total_bytes = byte_queue.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait on the falling edge so the queues are read between driver updates.
    @(negedge clk);
    while (byte_queue.size() != 0 || char_bus.valid) @(negedge clk);
    while (verdict_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (error_count == 0) begin
      $display("float_text_syntax_checker_core test passed");
    end else begin
      $display("float_text_syntax_checker_core test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fts_pkg.sv
rtl/fts_if.sv
rtl/fts_phase_next.sv
rtl/float_text_syntax_checker_core.sv
verif/tb.sv
